// ===== sv/elhs_pkg.sv =====
// Shared widths, reset values, register indexes and controller states of the level switch.
package elhs_pkg;

	// Field widths.
	localparam int SAMPLE_BITS   = 12;
	localparam int FRAC_BITS     = 16;
	localparam int ALPHA_BITS    = 16;
	localparam int PCT_BITS      = 7;
	localparam int FILT_BITS     = SAMPLE_BITS + FRAC_BITS;
	localparam int NUM_BITS      = SAMPLE_BITS + PCT_BITS;
	localparam int CNT_BITS      = $clog2(ALPHA_BITS);
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	// Full scale of the mapped level.
	localparam int PCT_MAX = 100;

	// Register reset values.
	localparam logic [SAMPLE_BITS-1:0] DRY_RESET   = SAMPLE_BITS'(3200);
	localparam logic [SAMPLE_BITS-1:0] WET_RESET   = SAMPLE_BITS'(1200);
	localparam logic [PCT_BITS-1:0]    LOW_RESET   = PCT_BITS'(30);
	localparam logic [PCT_BITS-1:0]    HIGH_RESET  = PCT_BITS'(45);
	localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET = ALPHA_BITS'(9830);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DRY_LEVEL   = 3'd0,
		CFG_WET_LEVEL   = 3'd1,
		CFG_LOW_THRESH  = 3'd2,
		CFG_HIGH_THRESH = 3'd3,
		CFG_SMOOTHING   = 3'd4
	} cfg_idx_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_PREP,
		ST_DIV,
		ST_HAND
	} state_t;

endpackage

// ===== sv/elhs_if.sv =====
// Request channels of the level switch: sample input and result output.
interface elhs_sample_if;
	logic                            valid;
	logic                            ready;
	logic [elhs_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface elhs_result_if;
	logic                            valid;
	logic                            ready;
	logic [elhs_pkg::SAMPLE_BITS-1:0] filtered_level;
	logic [elhs_pkg::PCT_BITS-1:0]    level_percent;
	logic                            switch_on;
	logic                            drive_n;

	modport source (output valid, output filtered_level, output level_percent,
		output switch_on, output drive_n, input ready);
	modport sink (input valid, input filtered_level, input level_percent,
		input switch_on, input drive_n, output ready);
endinterface

// ===== sv/ema_level_hysteresis_switch_unit.sv =====
// Top level of the smoothed level switch: filter, percent mapping and hysteresis.

// Each sample request runs through an exponential moving average held in Q12.16, is mapped
// from the dry/wet levels onto 0..100 percent and drives a hysteresis switch; one result
// request follows each sample. The unit works on one sample at a time: it accepts the
// sample, runs the bit-serial smoothing multiply (one bit of the smoothing weight per
// cycle), updates the filter, prepares the mapping, runs a restoring divider (one quotient
// bit per cycle) and loads the result register, waiting for it to be free. The result
// register frees the controller, so the next sample is taken while a result still waits
// downstream. The first sample after reset seeds the filter.
module ema_level_hysteresis_switch_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [elhs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [elhs_pkg::CFG_DATA_BITS-1:0] cfg_data,
	elhs_sample_if.sink                         sample_ch,
	elhs_result_if.source                       result_ch
);

	// Configuration registers.
	logic [elhs_pkg::SAMPLE_BITS-1:0] dry_q;
	logic [elhs_pkg::SAMPLE_BITS-1:0] wet_q;
	logic [elhs_pkg::PCT_BITS-1:0]    low_q;
	logic [elhs_pkg::PCT_BITS-1:0]    high_q;
	logic [elhs_pkg::ALPHA_BITS-1:0]  alpha_q;

	// Filter and switch state.
	logic [elhs_pkg::FILT_BITS-1:0] filt_q;
	logic                           seeded_q;
	logic                           switch_q;

	// Controller.
	elhs_pkg::state_t               state_q;
	elhs_pkg::state_t               state_nxt;
	logic [elhs_pkg::CNT_BITS-1:0]  cnt_q;

	// Multiply datapath.
	logic [elhs_pkg::FILT_BITS-1:0]  diff_q;
	logic                            neg_q;
	logic [elhs_pkg::FILT_BITS-1:0]  acc_q;
	logic [elhs_pkg::ALPHA_BITS-1:0] abits_q;

	// Mapping and divide datapath.
	logic [elhs_pkg::SAMPLE_BITS-1:0] rem_q;
	logic [elhs_pkg::SAMPLE_BITS-1:0] span_q;
	logic [elhs_pkg::PCT_BITS-1:0]    nbits_q;
	logic [elhs_pkg::PCT_BITS-1:0]    quot_q;
	logic                             force_zero_q;
	logic                             force_full_q;

	// Result register.
	logic                             res_valid_q;
	logic [elhs_pkg::SAMPLE_BITS-1:0] res_level_q;
	logic [elhs_pkg::PCT_BITS-1:0]    res_pct_q;
	logic                             res_switch_q;

	// Control outputs.
	logic accept;
	logic res_free;
	logic res_load;

	// Combinational datapath signals.
	logic [elhs_pkg::FILT_BITS-1:0]   x_full;
	logic [elhs_pkg::FILT_BITS:0]     x_minus_f;
	logic [elhs_pkg::FILT_BITS:0]     mul_sum;
	logic [elhs_pkg::SAMPLE_BITS-1:0] level;
	logic [elhs_pkg::SAMPLE_BITS:0]   a_sgn;
	logic [elhs_pkg::SAMPLE_BITS:0]   s_sgn;
	logic [elhs_pkg::SAMPLE_BITS-1:0] a_abs;
	logic [elhs_pkg::SAMPLE_BITS-1:0] s_abs;
	logic [elhs_pkg::NUM_BITS-1:0]    num;
	logic [elhs_pkg::SAMPLE_BITS:0]   trial;
	logic                             trial_ge;
	logic [elhs_pkg::PCT_BITS-1:0]    pct;
	logic                             switch_nxt;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			elhs_pkg::ST_IDLE: begin
				if (sample_ch.valid) state_nxt = elhs_pkg::ST_MUL;
			end
			elhs_pkg::ST_MUL: begin
				if (cnt_q == '0) state_nxt = elhs_pkg::ST_UPD;
			end
			elhs_pkg::ST_UPD:  state_nxt = elhs_pkg::ST_PREP;
			elhs_pkg::ST_PREP: state_nxt = elhs_pkg::ST_DIV;
			elhs_pkg::ST_DIV: begin
				if (cnt_q == '0) state_nxt = elhs_pkg::ST_HAND;
			end
			elhs_pkg::ST_HAND: begin
				if (res_free) state_nxt = elhs_pkg::ST_IDLE;
			end
			default: state_nxt = elhs_pkg::ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		res_free = !res_valid_q || result_ch.ready;
		accept   = 1'b0;
		res_load = 1'b0;
		case (state_q)
			elhs_pkg::ST_IDLE: accept   = sample_ch.valid;
			elhs_pkg::ST_HAND: res_load = res_free;
			default: begin
				accept   = 1'b0;
				res_load = 1'b0;
			end
		endcase
	end

	assign sample_ch.ready = (state_q == elhs_pkg::ST_IDLE);

	// Sample difference and one shift-add step of the multiply.
	always_comb begin
		x_full    = {sample_ch.sample, {elhs_pkg::FRAC_BITS{1'b0}}};
		x_minus_f = {1'b0, x_full} - {1'b0, filt_q};
		mul_sum   = {1'b0, acc_q} + (abits_q[0] ? {1'b0, diff_q} : '0);
	end

	// Signed offsets of the level and span from the dry level, and the scaled numerator.
	always_comb begin
		level = filt_q[elhs_pkg::FILT_BITS-1:elhs_pkg::FRAC_BITS];
		a_sgn = {1'b0, level} - {1'b0, dry_q};
		s_sgn = {1'b0, wet_q} - {1'b0, dry_q};
		a_abs = a_sgn[elhs_pkg::SAMPLE_BITS] ? elhs_pkg::SAMPLE_BITS'(-a_sgn)
		                                     : a_sgn[elhs_pkg::SAMPLE_BITS-1:0];
		s_abs = s_sgn[elhs_pkg::SAMPLE_BITS] ? elhs_pkg::SAMPLE_BITS'(-s_sgn)
		                                     : s_sgn[elhs_pkg::SAMPLE_BITS-1:0];
		num   = elhs_pkg::NUM_BITS'(a_abs) * elhs_pkg::NUM_BITS'(elhs_pkg::PCT_MAX);
	end

	// One restoring divide step.
	always_comb begin
		trial    = {rem_q, nbits_q[elhs_pkg::PCT_BITS-1]};
		trial_ge = (trial >= {1'b0, span_q});
	end

	// Final percent and hysteresis; the switch-on test wins when the thresholds overlap.
	always_comb begin
		if (force_zero_q) begin
			pct = '0;
		end else if (force_full_q) begin
			pct = elhs_pkg::PCT_BITS'(elhs_pkg::PCT_MAX);
		end else begin
			pct = quot_q;
		end
		if (pct < low_q) begin
			switch_nxt = 1'b1;
		end else if (pct > high_q) begin
			switch_nxt = 1'b0;
		end else begin
			switch_nxt = switch_q;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q   <= elhs_pkg::DRY_RESET;
			wet_q   <= elhs_pkg::WET_RESET;
			low_q   <= elhs_pkg::LOW_RESET;
			high_q  <= elhs_pkg::HIGH_RESET;
			alpha_q <= elhs_pkg::ALPHA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				elhs_pkg::CFG_DRY_LEVEL:   dry_q   <= cfg_data[elhs_pkg::SAMPLE_BITS-1:0];
				elhs_pkg::CFG_WET_LEVEL:   wet_q   <= cfg_data[elhs_pkg::SAMPLE_BITS-1:0];
				elhs_pkg::CFG_LOW_THRESH:  low_q   <= cfg_data[elhs_pkg::PCT_BITS-1:0];
				elhs_pkg::CFG_HIGH_THRESH: high_q  <= cfg_data[elhs_pkg::PCT_BITS-1:0];
				elhs_pkg::CFG_SMOOTHING:   alpha_q <= cfg_data[elhs_pkg::ALPHA_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Controller and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= elhs_pkg::ST_IDLE;
			seeded_q    <= 1'b0;
			switch_q    <= 1'b0;
			filt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept && !seeded_q) begin
				filt_q   <= x_full;
				seeded_q <= 1'b1;
			end else if (state_q == elhs_pkg::ST_UPD) begin
				filt_q <= neg_q ? filt_q - acc_q : filt_q + acc_q;
			end
			if (res_load) begin
				switch_q    <= switch_nxt;
				res_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Serial multiply and divide datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			elhs_pkg::ST_IDLE: begin
				if (seeded_q) begin
					neg_q  <= x_minus_f[elhs_pkg::FILT_BITS];
					diff_q <= x_minus_f[elhs_pkg::FILT_BITS]
					          ? elhs_pkg::FILT_BITS'(-x_minus_f)
					          : x_minus_f[elhs_pkg::FILT_BITS-1:0];
				end else begin
					// A seeding sample starts with a zero difference, so the step is zero.
					neg_q  <= 1'b0;
					diff_q <= '0;
				end
				acc_q   <= '0;
				abits_q <= alpha_q;
				cnt_q   <= elhs_pkg::CNT_BITS'(elhs_pkg::ALPHA_BITS - 1);
			end
			elhs_pkg::ST_MUL: begin
				acc_q   <= mul_sum[elhs_pkg::FILT_BITS:1];
				abits_q <= abits_q >> 1;
				cnt_q   <= cnt_q - 1'b1;
			end
			elhs_pkg::ST_PREP: begin
				// Opposite signs, a zero span or a zero offset give zero; an offset at
				// least as large as the span clamps to full scale.
				force_zero_q <= (s_abs == '0) || (a_abs == '0) ||
				                (a_sgn[elhs_pkg::SAMPLE_BITS] != s_sgn[elhs_pkg::SAMPLE_BITS]);
				force_full_q <= (a_abs >= s_abs);
				span_q       <= s_abs;
				rem_q        <= num[elhs_pkg::NUM_BITS-1:elhs_pkg::PCT_BITS];
				nbits_q      <= num[elhs_pkg::PCT_BITS-1:0];
				quot_q       <= '0;
				cnt_q        <= elhs_pkg::CNT_BITS'(elhs_pkg::PCT_BITS - 1);
			end
			elhs_pkg::ST_DIV: begin
				rem_q   <= trial_ge ? elhs_pkg::SAMPLE_BITS'(trial - {1'b0, span_q})
				                    : trial[elhs_pkg::SAMPLE_BITS-1:0];
				quot_q  <= {quot_q[elhs_pkg::PCT_BITS-2:0], trial_ge};
				nbits_q <= nbits_q << 1;
				cnt_q   <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_level_q  <= level;
			res_pct_q    <= pct;
			res_switch_q <= switch_nxt;
		end
	end

	assign result_ch.valid          = res_valid_q;
	assign result_ch.filtered_level = res_level_q;
	assign result_ch.level_percent  = res_pct_q;
	assign result_ch.switch_on      = res_switch_q;
	assign result_ch.drive_n        = !res_switch_q;

endmodule

// ===== test/elhs_checker.sv =====
// Result checker of the level switch: tracks filter, mapping and switch state, compares results.
module elhs_checker
	import elhs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	elhs_sample_if                   sample_ch,
	elhs_result_if                   result_ch,
	output int                       mismatch_count,
	output int                       levels_pending
);

	typedef struct {
		logic [SAMPLE_BITS-1:0] filtered_level;
		logic [PCT_BITS-1:0]    level_percent;
		logic                   switch_on;
		logic                   drive_n;
	} level_result_t;

	// Our own copy of the register file and of the filter state.
	logic [SAMPLE_BITS-1:0] dry_lvl;
	logic [SAMPLE_BITS-1:0] wet_lvl;
	logic [PCT_BITS-1:0]    low_pct;
	logic [PCT_BITS-1:0]    high_pct;
	logic [ALPHA_BITS-1:0]  alpha;
	logic [FILT_BITS-1:0]   filter_acc;
	logic                   seeded;
	logic                   switch_state;

	level_result_t expected_levels[$];
	int            fail_count = 0;

	assign mismatch_count = fail_count;

	// Works out the result of one sample request and advances the filter and the switch.
	function automatic level_result_t predict_level(input logic [SAMPLE_BITS-1:0] smp);
		logic [63:0]   target;
		logic [63:0]   acc;
		longint        lvl;
		longint        span;
		longint        pct;
		level_result_t res;
		target = 64'(smp) << FRAC_BITS;
		acc    = 64'(filter_acc);
		if (!seeded) begin
			acc = target;
		end else if (target >= acc) begin
			acc = acc + (((target - acc) * 64'(alpha)) >> ALPHA_BITS);
		end else begin
			acc = acc - (((acc - target) * 64'(alpha)) >> ALPHA_BITS);
		end
		filter_acc = FILT_BITS'(acc);
		seeded     = 1'b1;

		// Linear map from the dry level to the wet level, truncating toward zero.
		lvl  = longint'(filter_acc >> FRAC_BITS);
		span = longint'(wet_lvl) - longint'(dry_lvl);
		if (span == 0) begin
			pct = 0;
		end else begin
			pct = ((lvl - longint'(dry_lvl)) * longint'(PCT_MAX)) / span;
			if (pct < 0) pct = 0;
			if (pct > longint'(PCT_MAX)) pct = longint'(PCT_MAX);
		end

		// The switch-on test wins when the thresholds overlap.
		if (pct < longint'(low_pct)) begin
			switch_state = 1'b1;
		end else if (pct > longint'(high_pct)) begin
			switch_state = 1'b0;
		end

		res.filtered_level = SAMPLE_BITS'(lvl);
		res.level_percent  = PCT_BITS'(pct);
		res.switch_on      = switch_state;
		res.drive_n        = !switch_state;
		return res;
	endfunction

	// Compares one result request with the oldest expectation.
	task automatic compare_level(input level_result_t exp_res);
		if (result_ch.filtered_level !== exp_res.filtered_level) begin
			$error("filtered_level: expected %0d, actual %0d",
				exp_res.filtered_level, result_ch.filtered_level);
			fail_count++;
		end
		if (result_ch.level_percent !== exp_res.level_percent) begin
			$error("level_percent: expected %0d, actual %0d",
				exp_res.level_percent, result_ch.level_percent);
			fail_count++;
		end
		if (result_ch.switch_on !== exp_res.switch_on) begin
			$error("switch_on: expected %0d, actual %0d", exp_res.switch_on, result_ch.switch_on);
			fail_count++;
		end
		if (result_ch.drive_n !== exp_res.drive_n) begin
			$error("drive_n: expected %0d, actual %0d", exp_res.drive_n, result_ch.drive_n);
			fail_count++;
		end
	endtask

	// Follows register writes and both request channels at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_lvl      = DRY_RESET;
			wet_lvl      = WET_RESET;
			low_pct      = LOW_RESET;
			high_pct     = HIGH_RESET;
			alpha        = ALPHA_RESET;
			filter_acc   = '0;
			seeded       = 1'b0;
			switch_state = 1'b0;
			expected_levels.delete();
			levels_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DRY_LEVEL:   dry_lvl  = cfg_data[SAMPLE_BITS-1:0];
					CFG_WET_LEVEL:   wet_lvl  = cfg_data[SAMPLE_BITS-1:0];
					CFG_LOW_THRESH:  low_pct  = cfg_data[PCT_BITS-1:0];
					CFG_HIGH_THRESH: high_pct = cfg_data[PCT_BITS-1:0];
					CFG_SMOOTHING:   alpha    = cfg_data[ALPHA_BITS-1:0];
					default: ;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_levels.size() == 0) begin
					$error("result request with no sample outstanding: level %0d, percent %0d",
						result_ch.filtered_level, result_ch.level_percent);
					fail_count++;
				end else begin
					compare_level(expected_levels.pop_front());
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				expected_levels.push_back(predict_level(sample_ch.sample));
			end
			levels_pending <= expected_levels.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top of the level switch: clock, reset, register writes, sample stimulus and verdict.
module tb;
	import elhs_pkg::*;

	localparam int                       SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
	localparam logic [CFG_IDX_BITS-1:0]  CFG_SPARE_LOW  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0]  CFG_SPARE_HIGH = 3'd7;
	localparam logic [CFG_DATA_BITS-1:0] ALL_ONES       = '1;

	// Opening samples: seeding at full scale, both ends, the reset dry and wet levels
	// and a sweep through the reset hysteresis band.
	localparam logic [SAMPLE_BITS-1:0] OPENING_SAMPLES [18] = '{
		12'd4095, 12'd0, 12'd0, 12'd4095, 12'd3200, 12'd1200, 12'd1200, 12'd1200,
		12'd2048, 12'd2400, 12'd2600, 12'd2800, 12'd3000, 12'd1, 12'd4094,
		12'd2730, 12'd2600, 12'd2048
	};

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_SPARSE,
		STALL_LONG
	} stall_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int                       mismatch_count;
	int                       levels_pending;
	int                       burst_left = 0;
	logic [SAMPLE_BITS-1:0]   walk_target = '0;

	elhs_sample_if sample_ch();
	elhs_result_if result_ch();

	ema_level_hysteresis_switch_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	elhs_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_ch      (sample_ch),
		.result_ch      (result_ch),
		.mismatch_count (mismatch_count),
		.levels_pending (levels_pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// The result side stalls in stretches, each with its own pattern.
	initial begin
		int          hold = 0;
		stall_mode_t mode = STALL_NONE;
		logic        rdy;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				hold = int'($urandom_range(16, 160));
			end
			hold--;
			case (mode)
				STALL_NONE:   rdy = 1'b1;
				STALL_COIN:   rdy = 1'($urandom_range(0, 1));
				STALL_SPARSE: rdy = ($urandom_range(0, 7) == 0);
				default:      rdy = ((hold % 40) < 3);
			endcase
			result_ch.ready <= rdy;
		end
	end

	// Writes one register; called at a falling edge, returns at a falling edge.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Presents one sample request in bursts with random gaps and waits for its acceptance.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
		int gap;
		if (burst_left == 0) begin
			burst_left = int'($urandom_range(1, 40));
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 35));
			if (gap != 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= value;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	// Stops the sample side until every outstanding result request has arrived.
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (levels_pending != 0) @(negedge clk);
	endtask

	// Mostly a noisy level around a slowly moving target, so that the filtered level sweeps
	// through the thresholds; the rest is uniform noise and spikes to either end of the scale.
	function automatic logic [SAMPLE_BITS-1:0] next_sample();
		int v;
		if ($urandom_range(0, 39) == 0) walk_target = SAMPLE_BITS'($urandom);
		case ($urandom_range(0, 7))
			0:       v = int'($urandom_range(0, SAMPLE_MAX));
			1:       v = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
			default: v = int'(walk_target) + int'($urandom_range(0, 256)) - 128;
		endcase
		if (v < 0) v = 0;
		if (v > SAMPLE_MAX) v = SAMPLE_MAX;
		return SAMPLE_BITS'(v);
	endfunction

	task automatic run_random(input int count);
		repeat (count) begin
			if ($urandom_range(0, 199) == 0) wait_idle();
			send_sample(next_sample());
		end
	endtask

	// Random settings, with upper data bits that the registers drop and equal levels now and then.
	task automatic random_settings();
		logic [CFG_DATA_BITS-1:0] dry;
		logic [CFG_DATA_BITS-1:0] wet;
		logic [CFG_DATA_BITS-1:0] lo;
		logic [CFG_DATA_BITS-1:0] hi;
		logic [CFG_DATA_BITS-1:0] weight;
		dry = CFG_DATA_BITS'($urandom);
		case ($urandom_range(0, 3))
			0:       wet = dry;
			1:       wet = dry ^ CFG_DATA_BITS'(1);
			default: wet = CFG_DATA_BITS'($urandom);
		endcase
		lo = ($urandom_range(0, 1) == 1) ? CFG_DATA_BITS'($urandom_range(0, PCT_MAX))
			: CFG_DATA_BITS'($urandom);
		hi = ($urandom_range(0, 1) == 1) ? CFG_DATA_BITS'($urandom_range(0, PCT_MAX))
			: CFG_DATA_BITS'($urandom);
		case ($urandom_range(0, 3))
			0:       weight = CFG_DATA_BITS'($urandom_range(0, 255));
			1:       weight = ALL_ONES;
			default: weight = CFG_DATA_BITS'($urandom);
		endcase
		write_reg(CFG_DRY_LEVEL, dry);
		write_reg(CFG_WET_LEVEL, wet);
		write_reg(CFG_LOW_THRESH, lo);
		write_reg(CFG_HIGH_THRESH, hi);
		write_reg(CFG_SMOOTHING, weight);
		if ($urandom_range(0, 2) == 0) begin
			write_reg(CFG_IDX_BITS'($urandom_range(CFG_SPARE_LOW, CFG_SPARE_HIGH)),
				CFG_DATA_BITS'($urandom));
		end
	endtask

	// Main sequence: reset, directed samples, then phases of register settings.
	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: the first request seeds the filter.
		foreach (OPENING_SAMPLES[i]) send_sample(OPENING_SAMPLES[i]);
		run_random(250);
		wait_idle();

		// Weight at full scale and the widest mapping with the thresholds at the ends.
		write_reg(CFG_SMOOTHING, ALL_ONES);
		write_reg(CFG_DRY_LEVEL, '0);
		write_reg(CFG_WET_LEVEL, CFG_DATA_BITS'(SAMPLE_MAX));
		write_reg(CFG_LOW_THRESH, '0);
		write_reg(CFG_HIGH_THRESH, CFG_DATA_BITS'(PCT_MAX));
		send_sample('0);
		send_sample(SAMPLE_BITS'(SAMPLE_MAX));
		send_sample(SAMPLE_BITS'(SAMPLE_MAX / 2));
		send_sample('0);
		run_random(200);
		wait_idle();

		// Frozen filter, equal levels and overlapping thresholds.
		write_reg(CFG_SMOOTHING, '0);
		write_reg(CFG_DRY_LEVEL, CFG_DATA_BITS'(1000));
		write_reg(CFG_WET_LEVEL, CFG_DATA_BITS'(1000));
		write_reg(CFG_LOW_THRESH, ALL_ONES);
		write_reg(CFG_HIGH_THRESH, '0);
		run_random(100);
		wait_idle();

		// Inverted full-scale mapping, the smallest weight and thresholds at and above full scale.
		write_reg(CFG_DRY_LEVEL, ALL_ONES);
		write_reg(CFG_WET_LEVEL, '0);
		write_reg(CFG_SMOOTHING, CFG_DATA_BITS'(1));
		write_reg(CFG_LOW_THRESH, CFG_DATA_BITS'(PCT_MAX));
		write_reg(CFG_HIGH_THRESH, ALL_ONES);
		write_reg(CFG_SPARE_HIGH, ALL_ONES);
		run_random(150);

		repeat (6) begin
			wait_idle();
			random_settings();
			run_random(125);
		end

		wait_idle();
		repeat (40) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
